### src/i2cms_pkg.sv
package i2cms_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int BUF_IDX_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int BUF_FILL_W = $clog2(WRITE_DEPTH + 1);

  localparam int BYTE_BITS = 8;
  localparam int BIT_CNT_W = 4;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DETECT = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] operation;
    logic [6:0] device_address;
    logic [7:0] register_offset;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       failed;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
  } buf_ctl_t;

endpackage

### src/i2cms_wbuf.sv
module i2cms_wbuf (
  input  logic                            clk,
  input  logic                            rst,
  input  i2cms_pkg::buf_ctl_t             ctl,
  input  logic [7:0]                      wdata,
  input  logic [i2cms_pkg::BUF_IDX_W-1:0] rd_index,
  output logic [7:0]                      rd_data,
  output logic                            full
);

  logic [7:0]                       mem [i2cms_pkg::WRITE_DEPTH];
  logic [i2cms_pkg::BUF_FILL_W-1:0] fill;

  assign full = (fill == i2cms_pkg::BUF_FILL_W'(i2cms_pkg::WRITE_DEPTH));
  assign rd_data = mem[rd_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.clear) begin
      fill <= '0;
    end else if (ctl.load && !full) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && !full) begin
      mem[fill[i2cms_pkg::BUF_IDX_W-1:0]] <= wdata;
    end
  end

endmodule

### src/i2cms_core.sv
module i2cms_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  i2cms_pkg::in_item_t             item,
  input  logic [7:0]                      buf_data,
  input  logic                            buf_full,
  output i2cms_pkg::buf_ctl_t             buf_ctl,
  output logic [i2cms_pkg::BUF_IDX_W-1:0] buf_index,
  output i2cms_pkg::out_item_t            res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_SDA1, PH_ST_SCL1, PH_ST_SDA0, PH_ST_SCL0,
    PH_TX_LOW, PH_TX_DATA, PH_TX_HIGH,
    PH_AK_LOW, PH_AK_REL, PH_AK_HIGH, PH_AK_SAMPLE,
    PH_RX_LOW, PH_RX_HIGH,
    PH_NK_SDA1, PH_NK_SCL1, PH_NK_SCL0,
    PH_MA_SCL0, PH_MA_SDA0, PH_MA_SCL1, PH_MA_SCL0B, PH_MA_SDA1,
    PH_SP_SDA0, PH_SP_SCL0, PH_SP_SCL1, PH_SP_SDA1
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDR_W, STG_OFFSET, STG_ADDR_R, STG_DATA
  } stage_t;

  localparam logic [i2cms_pkg::BIT_CNT_W-1:0] BYTE_END =
    i2cms_pkg::BIT_CNT_W'(i2cms_pkg::BYTE_BITS);
  localparam logic [8:0] DEPTH_9 = 9'(i2cms_pkg::WRITE_DEPTH);

  phase_t                             phase, phase_next;
  stage_t                             stage, stage_next;
  logic [i2cms_pkg::BIT_CNT_W-1:0]    bit_index, bit_index_next;
  logic [7:0]                         shift_value, shift_value_next;
  logic [7:0]                         byte_index, byte_index_next;
  logic [1:0]                         current_operation, current_operation_next;
  logic [6:0]                         saved_address, saved_address_next;
  logic [7:0]                         saved_offset, saved_offset_next;
  logic [7:0]                         saved_count, saved_count_next;
  logic                               scl_level, scl_level_next;
  logic                               sda_level, sda_level_next;
  logic                               stop_fails, stop_fails_next;

  logic [8:0] write_len;
  logic [8:0] read_len;
  logic [7:0] data_index;
  logic       data_more;
  logic       rx_last;
  logic [7:0] rx_shift;

  assign write_len = ({1'b0, saved_count} < DEPTH_9) ? {1'b0, saved_count} : DEPTH_9;
  assign read_len = (saved_count == 8'd0) ? 9'd1 : {1'b0, saved_count};
  assign data_index = (stage == STG_OFFSET) ? 8'd0 : byte_index + 8'd1;
  assign data_more = ({1'b0, data_index} < write_len);
  assign buf_index = data_index[i2cms_pkg::BUF_IDX_W-1:0];
  assign rx_last = (({1'b0, byte_index} + 9'd1) >= read_len);
  assign rx_shift = (bit_index != '0) ? {shift_value[6:0], item.sda_in} : shift_value;

  always_comb begin
    phase_next = phase;
    stage_next = stage;
    bit_index_next = bit_index;
    shift_value_next = shift_value;
    byte_index_next = byte_index;
    current_operation_next = current_operation;
    saved_address_next = saved_address;
    saved_offset_next = saved_offset;
    saved_count_next = saved_count;
    scl_level_next = scl_level;
    sda_level_next = sda_level;
    stop_fails_next = stop_fails;
    buf_ctl = '0;
    res = '0;

    case (item.action)
      i2cms_pkg::ACT_LOAD: begin
        buf_ctl.load = accept && (phase == PH_IDLE) && !buf_full;
      end
      i2cms_pkg::ACT_START: begin
        if (phase == PH_IDLE && item.operation <= i2cms_pkg::OP_DETECT) begin
          current_operation_next = item.operation;
          saved_address_next = item.device_address;
          saved_offset_next = item.register_offset;
          saved_count_next = item.byte_count;
          buf_ctl.clear = accept && (item.operation == i2cms_pkg::OP_WRITE);
          byte_index_next = '0;
          bit_index_next = '0;
          stage_next = STG_ADDR_W;
          stop_fails_next = 1'b0;
          phase_next = PH_ST_SDA1;
        end
      end
      i2cms_pkg::ACT_TICK: begin
        case (phase)
          PH_ST_SDA1: begin sda_level_next = 1'b1; phase_next = PH_ST_SCL1; end
          PH_ST_SCL1: begin scl_level_next = 1'b1; phase_next = PH_ST_SDA0; end
          PH_ST_SDA0: begin sda_level_next = 1'b0; phase_next = PH_ST_SCL0; end
          PH_ST_SCL0: begin
            scl_level_next = 1'b0;
            bit_index_next = '0;
            phase_next = PH_TX_LOW;
            if (stage == STG_ADDR_R) begin
              shift_value_next = {saved_address, 1'b1};
              stage_next = STG_ADDR_R;
            end else begin
              shift_value_next = {saved_address, 1'b0};
              stage_next = STG_ADDR_W;
            end
          end
          PH_TX_LOW: begin scl_level_next = 1'b0; phase_next = PH_TX_DATA; end
          PH_TX_DATA: begin
            sda_level_next = shift_value[7];
            shift_value_next = {shift_value[6:0], 1'b0};
            phase_next = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            scl_level_next = 1'b1;
            bit_index_next = bit_index + 1'b1;
            phase_next = (bit_index_next >= BYTE_END) ? PH_AK_LOW : PH_TX_LOW;
          end
          PH_AK_LOW: begin scl_level_next = 1'b0; phase_next = PH_AK_REL; end
          PH_AK_REL: begin sda_level_next = 1'b1; phase_next = PH_AK_HIGH; end
          PH_AK_HIGH: begin scl_level_next = 1'b1; phase_next = PH_AK_SAMPLE; end
          PH_AK_SAMPLE: begin
            scl_level_next = 1'b0;
            if (item.sda_in) begin
              stop_fails_next = 1'b1;
              phase_next = PH_SP_SDA0;
            end else begin
              case (stage)
                STG_ADDR_W: begin
                  if (current_operation == i2cms_pkg::OP_DETECT) begin
                    stop_fails_next = 1'b0;
                    phase_next = PH_SP_SDA0;
                  end else begin
                    shift_value_next = saved_offset;
                    stage_next = STG_OFFSET;
                    bit_index_next = '0;
                    phase_next = PH_TX_LOW;
                  end
                end
                STG_ADDR_R: begin
                  byte_index_next = '0;
                  bit_index_next = '0;
                  shift_value_next = '0;
                  phase_next = PH_RX_LOW;
                end
                default: begin
                  if (stage == STG_OFFSET && current_operation == i2cms_pkg::OP_READ) begin
                    stage_next = STG_ADDR_R;
                    phase_next = PH_ST_SDA1;
                  end else begin
                    byte_index_next = data_index;
                    if (data_more) begin
                      shift_value_next = buf_data;
                      stage_next = STG_DATA;
                      bit_index_next = '0;
                      phase_next = PH_TX_LOW;
                    end else begin
                      stop_fails_next = 1'b0;
                      phase_next = PH_SP_SDA0;
                    end
                  end
                end
              endcase
            end
          end
          PH_RX_LOW: begin
            scl_level_next = 1'b0;
            shift_value_next = rx_shift;
            if (bit_index >= BYTE_END) begin
              res.read_byte = rx_shift;
              res.read_valid = 1'b1;
              if (rx_last) begin
                res.read_last = 1'b1;
                phase_next = PH_NK_SDA1;
              end else begin
                byte_index_next = byte_index + 8'd1;
                phase_next = PH_MA_SCL0;
              end
            end else begin
              phase_next = PH_RX_HIGH;
            end
          end
          PH_RX_HIGH: begin
            scl_level_next = 1'b1;
            bit_index_next = bit_index + 1'b1;
            phase_next = PH_RX_LOW;
          end
          PH_NK_SDA1: begin sda_level_next = 1'b1; phase_next = PH_NK_SCL1; end
          PH_NK_SCL1: begin scl_level_next = 1'b1; phase_next = PH_NK_SCL0; end
          PH_NK_SCL0: begin
            scl_level_next = 1'b0;
            stop_fails_next = 1'b0;
            phase_next = PH_SP_SDA0;
          end
          PH_MA_SCL0: begin scl_level_next = 1'b0; phase_next = PH_MA_SDA0; end
          PH_MA_SDA0: begin sda_level_next = 1'b0; phase_next = PH_MA_SCL1; end
          PH_MA_SCL1: begin scl_level_next = 1'b1; phase_next = PH_MA_SCL0B; end
          PH_MA_SCL0B: begin scl_level_next = 1'b0; phase_next = PH_MA_SDA1; end
          PH_MA_SDA1: begin
            sda_level_next = 1'b1;
            bit_index_next = '0;
            shift_value_next = '0;
            phase_next = PH_RX_LOW;
          end
          PH_SP_SDA0: begin sda_level_next = 1'b0; phase_next = PH_SP_SCL0; end
          PH_SP_SCL0: begin scl_level_next = 1'b0; phase_next = PH_SP_SCL1; end
          PH_SP_SCL1: begin scl_level_next = 1'b1; phase_next = PH_SP_SDA1; end
          PH_SP_SDA1: begin
            sda_level_next = 1'b1;
            res.done_res = 1'b1;
            res.failed = stop_fails;
            stop_fails_next = 1'b0;
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    res.scl_out = scl_level_next;
    res.sda_out = sda_level_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      stage <= STG_ADDR_W;
      bit_index <= '0;
      shift_value <= '0;
      byte_index <= '0;
      current_operation <= '0;
      saved_address <= '0;
      saved_offset <= '0;
      saved_count <= '0;
      scl_level <= 1'b1;
      sda_level <= 1'b1;
      stop_fails <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      stage <= stage_next;
      bit_index <= bit_index_next;
      shift_value <= shift_value_next;
      byte_index <= byte_index_next;
      current_operation <= current_operation_next;
      saved_address <= saved_address_next;
      saved_offset <= saved_offset_next;
      saved_count <= saved_count_next;
      scl_level <= scl_level_next;
      sda_level <= sda_level_next;
      stop_fails <= stop_fails_next;
    end
  end

endmodule

### src/i2c_master_bitbang_sequencer_unit.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data (in_item_t)
// out      output     out_valid / out_ready out_data (out_item_t)
//
// Every request yields one result, registered in the cycle after it is taken.
// A new request is taken each cycle while the result register is empty or being drained.
// When out_ready stays low, the held result blocks further requests.
// Synchronous reset idles the sequencer with both lines released and an empty write buffer.
module i2c_master_bitbang_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_data
);

  logic                            accept;
  i2cms_pkg::buf_ctl_t             buf_ctl;
  logic [i2cms_pkg::BUF_IDX_W-1:0] buf_index;
  logic [7:0]                      buf_data;
  logic                            buf_full;
  i2cms_pkg::out_item_t            res_next;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  i2cms_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .buf_data (buf_data),
    .buf_full (buf_full),
    .buf_ctl  (buf_ctl),
    .buf_index(buf_index),
    .res      (res_next)
  );

  i2cms_wbuf u_wbuf (
    .clk     (clk),
    .rst     (rst),
    .ctl     (buf_ctl),
    .wdata   (in_data.write_byte),
    .rd_index(buf_index),
    .rd_data (buf_data),
    .full    (buf_full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_last |-> out_data.read_valid)
    else $error("read_last without read_valid");

  a_fail_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.failed |-> out_data.done_res)
    else $error("failed without done");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

endmodule

### tb/sv/i2c_master_bitbang_sequencer_unit_tb.sv
`timescale 1ns / 100ps

module i2c_master_bitbang_sequencer_unit_tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NO_NACK = -1;
  localparam int RANDOM_LEVEL = 2;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef enum logic [4:0] {
    SEQ_IDLE, START_SDA_HI, START_SCL_HI, START_SDA_LO, START_SCL_LO,
    TX_SCL_LO, TX_SDA_SET, TX_SCL_HI,
    ACK_SCL_LO, ACK_SDA_REL, ACK_SCL_HI, ACK_SAMPLE,
    RX_SCL_LO, RX_SCL_HI,
    NACK_SDA_HI, NACK_SCL_HI, NACK_SCL_LO,
    MACK_SCL_LO, MACK_SDA_LO, MACK_SCL_HI, MACK_SCL_LO2, MACK_SDA_HI,
    STOP_SDA_LO, STOP_SCL_LO, STOP_SCL_HI, STOP_SDA_HI
  } seq_phase_e;

  typedef enum logic [1:0] {XS_ADDR_WR, XS_OFFSET, XS_ADDR_RD, XS_DATA} xfer_stage_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  i2cms_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  i2cms_pkg::out_item_t out_data;

  i2c_master_bitbang_sequencer_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  seq_phase_e m_phase;
  xfer_stage_e m_stage;
  int m_bit_cnt;
  int m_byte_cnt;
  int m_fill;
  logic [7:0] m_shift;
  logic [7:0] m_wbuf [i2cms_pkg::WRITE_DEPTH];
  logic [1:0] m_op;
  logic [6:0] m_addr;
  logic [7:0] m_offset;
  logic [7:0] m_count;
  logic m_scl;
  logic m_sda;
  bit m_stop_fail;
  int loaded_depth;

  i2cms_pkg::out_item_t awaited_bus_out[$];
  i2cms_pkg::out_item_t want;
  int unsigned mismatches = 0;
  int effective_count = 0;
  bit steady = 1'b0;
  bit stall_request = 1'b0;
  int stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void model_reset();
    m_phase = SEQ_IDLE;
    m_stage = XS_ADDR_WR;
    m_bit_cnt = 0;
    m_byte_cnt = 0;
    m_fill = 0;
    m_shift = '0;
    foreach (m_wbuf[i]) m_wbuf[i] = '0;
    m_op = i2cms_pkg::OP_READ;
    m_addr = '0;
    m_offset = '0;
    m_count = '0;
    m_scl = 1'b1;
    m_sda = 1'b1;
    m_stop_fail = 1'b0;
    loaded_depth = 0;
  endfunction

  function automatic void shift_out(input logic [7:0] value, input xfer_stage_e stg);
    m_shift = value;
    m_stage = stg;
    m_bit_cnt = 0;
    m_phase = TX_SCL_LO;
  endfunction

  function automatic void go_stop(input bit fail);
    m_stop_fail = fail;
    m_phase = STOP_SDA_LO;
  endfunction

  function automatic void next_write_byte();
    int len;
    len = (m_count < i2cms_pkg::WRITE_DEPTH) ? int'(m_count) : i2cms_pkg::WRITE_DEPTH;
    if (m_byte_cnt < len) shift_out(m_wbuf[m_byte_cnt % i2cms_pkg::WRITE_DEPTH], XS_DATA);
    else go_stop(1'b0);
  endfunction

  function automatic i2cms_pkg::out_item_t sequencer_predict(input i2cms_pkg::in_item_t req,
                                                             output bit taken);
    i2cms_pkg::out_item_t res;
    int rd_len;
    res = '0;
    taken = 1'b0;
    rd_len = (m_count == 0) ? 1 : int'(m_count);
    case (req.action)
      i2cms_pkg::ACT_LOAD: begin
        if (m_phase == SEQ_IDLE && m_fill < i2cms_pkg::WRITE_DEPTH) begin
          m_wbuf[m_fill] = req.write_byte;
          m_fill++;
          if (m_fill > loaded_depth) loaded_depth = m_fill;
          taken = 1'b1;
        end
      end
      i2cms_pkg::ACT_START: begin
        if (m_phase == SEQ_IDLE && req.operation != OP_UNUSED) begin
          m_op = req.operation;
          m_addr = req.device_address;
          m_offset = req.register_offset;
          m_count = req.byte_count;
          if (req.operation == i2cms_pkg::OP_WRITE) m_fill = 0;
          m_byte_cnt = 0;
          m_bit_cnt = 0;
          m_stage = XS_ADDR_WR;
          m_stop_fail = 1'b0;
          m_phase = START_SDA_HI;
          taken = 1'b1;
        end
      end
      i2cms_pkg::ACT_TICK: begin
        taken = (m_phase != SEQ_IDLE);
        case (m_phase)
          START_SDA_HI: begin m_sda = 1'b1; m_phase = START_SCL_HI; end
          START_SCL_HI: begin m_scl = 1'b1; m_phase = START_SDA_LO; end
          START_SDA_LO: begin m_sda = 1'b0; m_phase = START_SCL_LO; end
          START_SCL_LO: begin
            m_scl = 1'b0;
            if (m_stage == XS_ADDR_RD) shift_out({m_addr, 1'b1}, XS_ADDR_RD);
            else shift_out({m_addr, 1'b0}, XS_ADDR_WR);
          end
          TX_SCL_LO: begin m_scl = 1'b0; m_phase = TX_SDA_SET; end
          TX_SDA_SET: begin
            m_sda = m_shift[7];
            m_shift = {m_shift[6:0], 1'b0};
            m_phase = TX_SCL_HI;
          end
          TX_SCL_HI: begin
            m_scl = 1'b1;
            m_bit_cnt++;
            m_phase = (m_bit_cnt >= 8) ? ACK_SCL_LO : TX_SCL_LO;
          end
          ACK_SCL_LO: begin m_scl = 1'b0; m_phase = ACK_SDA_REL; end
          ACK_SDA_REL: begin m_sda = 1'b1; m_phase = ACK_SCL_HI; end
          ACK_SCL_HI: begin m_scl = 1'b1; m_phase = ACK_SAMPLE; end
          ACK_SAMPLE: begin
            m_scl = 1'b0;
            if (req.sda_in) begin
              go_stop(1'b1);
            end else begin
              case (m_stage)
                XS_ADDR_WR: begin
                  if (m_op == i2cms_pkg::OP_DETECT) go_stop(1'b0);
                  else shift_out(m_offset, XS_OFFSET);
                end
                XS_OFFSET: begin
                  if (m_op == i2cms_pkg::OP_READ) begin
                    m_stage = XS_ADDR_RD;
                    m_phase = START_SDA_HI;
                  end else begin
                    m_byte_cnt = 0;
                    next_write_byte();
                  end
                end
                XS_ADDR_RD: begin
                  m_byte_cnt = 0;
                  m_bit_cnt = 0;
                  m_shift = '0;
                  m_phase = RX_SCL_LO;
                end
                default: begin
                  m_byte_cnt++;
                  next_write_byte();
                end
              endcase
            end
          end
          RX_SCL_LO: begin
            m_scl = 1'b0;
            if (m_bit_cnt > 0) m_shift = {m_shift[6:0], req.sda_in};
            if (m_bit_cnt >= 8) begin
              res.read_byte = m_shift;
              res.read_valid = 1'b1;
              if (m_byte_cnt + 1 >= rd_len) begin
                res.read_last = 1'b1;
                m_phase = NACK_SDA_HI;
              end else begin
                m_byte_cnt++;
                m_phase = MACK_SCL_LO;
              end
            end else begin
              m_phase = RX_SCL_HI;
            end
          end
          RX_SCL_HI: begin m_scl = 1'b1; m_bit_cnt++; m_phase = RX_SCL_LO; end
          NACK_SDA_HI: begin m_sda = 1'b1; m_phase = NACK_SCL_HI; end
          NACK_SCL_HI: begin m_scl = 1'b1; m_phase = NACK_SCL_LO; end
          NACK_SCL_LO: begin m_scl = 1'b0; go_stop(1'b0); end
          MACK_SCL_LO: begin m_scl = 1'b0; m_phase = MACK_SDA_LO; end
          MACK_SDA_LO: begin m_sda = 1'b0; m_phase = MACK_SCL_HI; end
          MACK_SCL_HI: begin m_scl = 1'b1; m_phase = MACK_SCL_LO2; end
          MACK_SCL_LO2: begin m_scl = 1'b0; m_phase = MACK_SDA_HI; end
          MACK_SDA_HI: begin
            m_sda = 1'b1;
            m_bit_cnt = 0;
            m_shift = '0;
            m_phase = RX_SCL_LO;
          end
          STOP_SDA_LO: begin m_sda = 1'b0; m_phase = STOP_SCL_LO; end
          STOP_SCL_LO: begin m_scl = 1'b0; m_phase = STOP_SCL_HI; end
          STOP_SCL_HI: begin m_scl = 1'b1; m_phase = STOP_SDA_HI; end
          STOP_SDA_HI: begin
            m_sda = 1'b1;
            res.done_res = 1'b1;
            res.failed = m_stop_fail;
            m_stop_fail = 1'b0;
            m_phase = SEQ_IDLE;
          end
          default: m_phase = SEQ_IDLE;
        endcase
      end
      default: ;
    endcase
    res.scl_out = m_scl;
    res.sda_out = m_sda;
    res.busy_res = (m_phase != SEQ_IDLE);
    return res;
  endfunction

  function automatic i2cms_pkg::in_item_t random_item();
    i2cms_pkg::in_item_t r;
    r.action = 2'($urandom_range(3));
    r.operation = 2'($urandom_range(3));
    r.device_address = 7'($urandom_range(127));
    r.register_offset = 8'($urandom_range(255));
    r.byte_count = 8'($urandom_range(255));
    r.write_byte = 8'($urandom_range(255));
    r.sda_in = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic send_request(input i2cms_pkg::in_item_t req);
    i2cms_pkg::out_item_t res;
    bit taken;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    res = sequencer_predict(req, taken);
    awaited_bus_out.push_back(res);
    if (taken) effective_count++;
  endtask

  task automatic load_byte(input logic [7:0] value);
    i2cms_pkg::in_item_t req;
    req = random_item();
    req.action = i2cms_pkg::ACT_LOAD;
    req.write_byte = value;
    send_request(req);
  endtask

  task automatic run_transfer(input logic [1:0] op, input logic [6:0] addr,
                              input logic [7:0] offset, input logic [7:0] count,
                              input int nack_at, input int noise_pct, input int level);
    i2cms_pkg::in_item_t req;
    int ack_no;
    req = random_item();
    req.action = i2cms_pkg::ACT_START;
    req.operation = op;
    req.device_address = addr;
    req.register_offset = offset;
    req.byte_count = count;
    send_request(req);
    ack_no = 0;
    while (m_phase != SEQ_IDLE) begin
      req = random_item();
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: req.action = i2cms_pkg::ACT_LOAD;
          1: req.action = i2cms_pkg::ACT_START;
          default: req.action = ACT_UNUSED;
        endcase
      end else begin
        req.action = i2cms_pkg::ACT_TICK;
        if (level != RANDOM_LEVEL) req.sda_in = 1'(level);
        if (m_phase == ACK_SAMPLE) begin
          req.sda_in = (ack_no == nack_at);
          ack_no++;
        end
      end
      send_request(req);
    end
  endtask

  task automatic test_idle_requests();
    i2cms_pkg::in_item_t req;
    req = random_item();
    req.action = i2cms_pkg::ACT_TICK;
    send_request(req);
    req.action = ACT_UNUSED;
    send_request(req);
    req.action = i2cms_pkg::ACT_START;
    req.operation = OP_UNUSED;
    send_request(req);
    req.action = i2cms_pkg::ACT_TICK;
    send_request(req);
  endtask

  task automatic test_detect();
    run_transfer(i2cms_pkg::OP_DETECT, 7'h00, 8'h00, 8'h00, NO_NACK, 0, RANDOM_LEVEL);
    run_transfer(i2cms_pkg::OP_DETECT, 7'h7f, 8'hff, 8'hff, 0, 0, RANDOM_LEVEL);
  endtask

  task automatic test_write();
    for (int i = 0; i < i2cms_pkg::WRITE_DEPTH; i++) load_byte(8'(i * 17));
    // The buffer is full, so this load must be dropped.
    load_byte(8'h5a);
    run_transfer(i2cms_pkg::OP_WRITE, 7'h55, 8'hff, 8'hff, 4, 10, RANDOM_LEVEL);
    run_transfer(i2cms_pkg::OP_WRITE, 7'h2a, 8'h00, 8'h00, NO_NACK, 0, RANDOM_LEVEL);
    load_byte(8'hff);
    load_byte(8'h00);
    run_transfer(i2cms_pkg::OP_WRITE, 7'h11, 8'h3c, 8'h02, 2, 0, RANDOM_LEVEL);
    run_transfer(i2cms_pkg::OP_WRITE, 7'h12, 8'hc3, 8'h03, 1, 0, RANDOM_LEVEL);
  endtask

  task automatic test_read();
    run_transfer(i2cms_pkg::OP_READ, 7'h50, 8'h00, 8'h00, NO_NACK, 0, 1);
    run_transfer(i2cms_pkg::OP_READ, 7'h2f, 8'h80, 8'h03, NO_NACK, 0, 0);
    run_transfer(i2cms_pkg::OP_READ, 7'h51, 8'h7f, 8'h02, NO_NACK, 10, RANDOM_LEVEL);
    run_transfer(i2cms_pkg::OP_READ, 7'h52, 8'h01, 8'h04, 2, 0, RANDOM_LEVEL);
    run_transfer(i2cms_pkg::OP_READ, 7'h7f, 8'hfe, 8'hff, 1, 0, RANDOM_LEVEL);
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    stall_request = 1'b1;
    run_transfer(i2cms_pkg::OP_READ, 7'h33, 8'h44, 8'h04, NO_NACK, 0, RANDOM_LEVEL);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    i2cms_pkg::in_item_t req;
    logic [1:0] op;
    logic [7:0] count;
    int nack_at;
    int loads;
    effective_count = 0;
    while (effective_count < RANDOM_ITEMS) begin
      steady = (effective_count > 50 && effective_count < 200);
      if ($urandom_range(99) < 10) begin
        // Stray requests between transfers; none of them may start one.
        req = random_item();
        case ($urandom_range(3))
          0: req.action = i2cms_pkg::ACT_LOAD;
          1: req.action = i2cms_pkg::ACT_TICK;
          2: req.action = ACT_UNUSED;
          default: begin
            req.action = i2cms_pkg::ACT_START;
            req.operation = OP_UNUSED;
          end
        endcase
        send_request(req);
      end else begin
        op = 2'($urandom_range(2));
        nack_at = ($urandom_range(99) < 15) ? $urandom_range(3) : NO_NACK;
        count = 8'($urandom_range(4));
        if (op == i2cms_pkg::OP_WRITE) begin
          loads = ($urandom_range(9) == 0) ? i2cms_pkg::WRITE_DEPTH + 2 :
                  $urandom_range(i2cms_pkg::WRITE_DEPTH);
          repeat (loads) load_byte(8'($urandom_range(255)));
          if (loaded_depth < i2cms_pkg::WRITE_DEPTH) count = 8'($urandom_range(loaded_depth));
          else if ($urandom_range(2) == 0) count = 8'($urandom_range(255));
          else count = 8'($urandom_range(i2cms_pkg::WRITE_DEPTH));
        end else if (op == i2cms_pkg::OP_DETECT) begin
          count = 8'($urandom_range(255));
        end
        run_transfer(op, 7'($urandom_range(127)), 8'($urandom_range(255)), count,
                     nack_at, 4, RANDOM_LEVEL);
      end
    end
    steady = 1'b0;
  endtask

  function automatic void flag_mismatch(input string field, input int unsigned exp_v,
                                        input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_bus_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = awaited_bus_out.pop_front();
        if (out_data.scl_out !== want.scl_out)
          flag_mismatch("scl_out", want.scl_out, out_data.scl_out);
        if (out_data.sda_out !== want.sda_out)
          flag_mismatch("sda_out", want.sda_out, out_data.sda_out);
        if (out_data.read_byte !== want.read_byte)
          flag_mismatch("read_byte", want.read_byte, out_data.read_byte);
        if (out_data.read_valid !== want.read_valid)
          flag_mismatch("read_valid", want.read_valid, out_data.read_valid);
        if (out_data.read_last !== want.read_last)
          flag_mismatch("read_last", want.read_last, out_data.read_last);
        if (out_data.busy_res !== want.busy_res)
          flag_mismatch("busy_res", want.busy_res, out_data.busy_res);
        if (out_data.done_res !== want.done_res)
          flag_mismatch("done_res", want.done_res, out_data.done_res);
        if (out_data.failed !== want.failed)
          flag_mismatch("failed", want.failed, out_data.failed);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 12) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_requests();
    test_detect();
    test_write();
    test_read();
    test_backpressure();
    test_random_traffic();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_bus_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
